FILE: sv/stce_pkg.sv
// ----------------------------------------------------------------------------
// stce_pkg
// Shared types and constants of the system track cell encoder.
// ----------------------------------------------------------------------------
package stce_pkg;

  localparam int POS_W = 20;
  localparam int LEN_W = 21;
  localparam int CFG_W = 21;

  localparam logic [LEN_W-1:0] LEN_MIN = 21'd64;
  localparam logic [7:0] BYTE_GAP  = 8'h00;
  localparam logic [7:0] BYTE_SYNC = 8'hFF;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_GAP    = 3'd1,
    OP_SYNC   = 3'd2,
    OP_DATA   = 3'd3,
    OP_CKLOW  = 3'd4,
    OP_CKHIGH = 3'd5,
    OP_FILL   = 3'd6
  } opcode_e;

  typedef enum logic [0:0] {
    REG_TRACK_CELLS = 1'b0,
    REG_CKSUM_REGEN = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [23:0] pattern;
    logic [4:0]  count;
  } cell_code_t;

endpackage

FILE: sv/stce_cell_coder.sv
// ----------------------------------------------------------------------------
// stce_cell_coder
// Codes one byte into flux cells, lsb first: one -> 0,0,1, zero -> 0,1.
// ----------------------------------------------------------------------------
module stce_cell_coder
  import stce_pkg::*;
(
  input  logic [7:0] byte_i,
  output cell_code_t code_o
);

  logic [23:0] pat;
  logic [4:0]  cnt;

  always_comb begin
    pat = '0;
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      if (byte_i[k]) begin
        pat = {pat[20:0], 3'b001};
        cnt = cnt + 5'd3;
      end else begin
        pat = {pat[21:0], 2'b01};
        cnt = cnt + 5'd2;
      end
    end
    // left-align so the first cell sits in bit 23
    code_o.pattern = pat << (5'd24 - cnt);
    code_o.count   = cnt;
  end

endmodule

FILE: sv/system_track_cell_encoder.sv
// ----------------------------------------------------------------------------
// system_track_cell_encoder
// Track byte to flux cell encoder with checksum handling and track wrap.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a blocked result holds the
//   byte in the input register until the result is taken.
// Throughput: one byte per cycle while the result is not blocked.
// Reset: asynchronous, active low; clears position, checksum, mismatch flag,
//   pipeline valids and loads the register reset values.
module system_track_cell_encoder
  import stce_pkg::*;
#(
  parameter int MAX_TRACK_CELLS = 1048576
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]        s_axis_tuser,   // [2:0] opcode
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [23:0] cell_pattern, [28:24] cell_count, [48:29] first_cell_position,
  // [49] wrapped, [50] checksum_error, [55:51] zero
  output logic [55:0]       m_axis_tdata
);

  localparam int LenCap = (MAX_TRACK_CELLS < 1048576) ? MAX_TRACK_CELLS : 1048576;
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(LenCap);

  // configuration
  logic [LEN_W-1:0] track_q;
  logic             regen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= 21'd200000;
      regen_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_addr_i))
        REG_TRACK_CELLS: track_q <= cfg_wdata_i[LEN_W-1:0];
        REG_CKSUM_REGEN: regen_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [2:0] in_op_q;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       produces;

  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // track state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic             lowmis_q, lowmis_d;

  logic [7:0] byte_sel;
  logic       err;

  always_comb begin
    produces = 1'b0;
    byte_sel = BYTE_GAP;
    err      = 1'b0;
    sum_d    = sum_q;
    lowmis_d = lowmis_q;
    case (opcode_e'(in_op_q))
      OP_BEGIN: begin
        sum_d    = '0;
        lowmis_d = 1'b0;
      end
      OP_GAP: begin
        produces = 1'b1;
        byte_sel = BYTE_GAP;
      end
      OP_SYNC: begin
        produces = 1'b1;
        byte_sel = BYTE_SYNC;
      end
      OP_DATA: begin
        produces = 1'b1;
        byte_sel = in_byte_q;
        sum_d    = sum_q + {8'd0, in_byte_q};
      end
      OP_CKLOW: begin
        produces = 1'b1;
        if (regen_q) begin
          byte_sel = sum_q[7:0];
          lowmis_d = 1'b0;
        end else begin
          byte_sel = in_byte_q;
          lowmis_d = (in_byte_q != sum_q[7:0]);
        end
      end
      OP_CKHIGH: begin
        produces = 1'b1;
        if (regen_q) begin
          byte_sel = sum_q[15:8];
        end else begin
          byte_sel = in_byte_q;
          err      = lowmis_q || (in_byte_q != sum_q[15:8]);
        end
      end
      OP_FILL: begin
        produces = 1'b1;
        byte_sel = sum_q[15:8];
      end
      default: ;
    endcase
  end

  cell_code_t code;

  stce_cell_coder u_coder (
    .byte_i (byte_sel),
    .code_o (code)
  );

  // effective track length and position advance
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] pos_end;
  logic [LEN_W-1:0] pos_late;
  logic             early;
  logic             late;
  logic [POS_W-1:0] first;
  logic             wrap;

  always_comb begin
    if (track_q < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (track_q > LenMax) begin
      eff_len = LenMax;
    end else begin
      eff_len = track_q;
    end
    pos_inc  = {1'b0, pos_q} + 21'd1;
    pos_end  = {1'b0, pos_q} + LEN_W'(code.count);
    pos_late = pos_end - eff_len;
    // first cell wraps, e.g. after the length shrank mid-track
    early    = (pos_inc >= eff_len);
    late     = (pos_end >= eff_len);
    first    = early ? '0 : pos_inc[POS_W-1:0];
    wrap     = early || late;
    if (!produces) begin
      pos_d = (opcode_e'(in_op_q) == OP_BEGIN) ? '0 : pos_q;
    end else if (early) begin
      pos_d = POS_W'(code.count - 5'd1);
    end else if (late) begin
      pos_d = pos_late[POS_W-1:0];
    end else begin
      pos_d = pos_end[POS_W-1:0];
    end
  end

  logic out_valid_q;

  assign fire = in_valid_q && (!produces || !out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      lowmis_q <= 1'b0;
    end else if (fire) begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      lowmis_q <= lowmis_d;
    end
  end

  // result register
  logic [23:0]      out_pattern_q;
  logic [4:0]       out_count_q;
  logic [POS_W-1:0] out_first_q;
  logic             out_wrap_q;
  logic             out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && produces) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && produces) begin
      out_pattern_q <= code.pattern;
      out_count_q   <= code.count;
      out_first_q   <= first;
      out_wrap_q    <= wrap;
      out_err_q     <= err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_err_q, out_wrap_q, out_first_q, out_count_q,
                          out_pattern_q};

  // checks
  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && opcode_e'(in_op_q) == OP_BEGIN) |=> (pos_q == '0 && sum_q == '0 && !lowmis_q))
    else $error("begin track did not clear the track state");

  a_first_in_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && produces) |=> ({1'b0, out_first_q} < $past(eff_len)))
    else $error("first cell position outside the track");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_err_only_ckhigh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && produces && opcode_e'(in_op_q) != OP_CKHIGH) |=> !out_err_q)
    else $error("checksum error flagged outside checksum high");

endmodule

FILE: bench/system_track_cell_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// system_track_cell_encoder_tb
// Self-checking bench for the track byte to flux cell encoder: directed
// frames, checksum verify and regenerate, wrap at short and clamped track
// lengths, then random frames under changing idle on both streams.
// ----------------------------------------------------------------------------
module system_track_cell_encoder_tb;
  import stce_pkg::*;

  localparam int unsigned TRACK_MAX = 1048576;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int LAT_SLACK = 4;

  // lowest field in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic        cksum_err;
    logic        wrapped;
    logic [19:0] first_pos;
    logic [4:0]  count;
    logic [23:0] pattern;
  } cell_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [0:0]       cfg_addr_i = REG_TRACK_CELLS;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic [2:0]       s_axis_tuser = OP_BEGIN;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [55:0]      m_axis_tdata;

  // encoder image: configuration and track state
  logic [LEN_W-1:0] cfg_track_cells;
  logic             cfg_regen;
  logic [19:0]      trk_pos;
  logic [15:0]      trk_sum;
  logic             low_bad;

  cell_result_t expected_cells[$];
  int mismatches = 0;
  int cells_sent = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  system_track_cell_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    if (mismatches < 100) begin
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
    end
    mismatches++;
  endtask

  function automatic void reset_image();
    cfg_track_cells = 21'd200000;
    cfg_regen = 1'b0;
    trk_pos = '0;
    trk_sum = '0;
    low_bad = 1'b0;
  endfunction

  // codes one byte into cells and updates position and checksum
  function automatic void encode_byte(logic [2:0] op, logic [7:0] din);
    logic [7:0]   cbyte;
    logic         err;
    int unsigned  len, pos, first_pos, pattern, count, cells;
    bit           wrap;
    cell_result_t res;
    cbyte = 8'h00;
    err = 1'b0;
    wrap = 1'b0;
    first_pos = 0;
    pattern = 0;
    count = 0;
    case (op)
      OP_BEGIN: begin
        trk_pos = '0;
        trk_sum = '0;
        low_bad = 1'b0;
        return;
      end
      OP_GAP:  cbyte = BYTE_GAP;
      OP_SYNC: cbyte = BYTE_SYNC;
      OP_DATA: begin
        cbyte = din;
        trk_sum = trk_sum + din;
      end
      OP_CKLOW: begin
        if (cfg_regen) begin
          cbyte = trk_sum[7:0];
          low_bad = 1'b0;
        end else begin
          cbyte = din;
          low_bad = (din != trk_sum[7:0]);
        end
      end
      OP_CKHIGH: begin
        if (cfg_regen) begin
          cbyte = trk_sum[15:8];
        end else begin
          cbyte = din;
          err = low_bad || (din != trk_sum[15:8]);
        end
      end
      OP_FILL: cbyte = trk_sum[15:8];
      default: return;
    endcase
    len = cfg_track_cells;
    if (len < LEN_MIN) len = LEN_MIN;
    if (len > TRACK_MAX) len = TRACK_MAX;
    pos = trk_pos;
    for (int k = 0; k < 8; k++) begin
      cells = cbyte[k] ? 3 : 2;
      for (int unsigned c = 0; c < cells; c++) begin
        pos = pos + 1;
        if (pos >= len) begin
          pos = 0;
          wrap = 1'b1;
        end
        if (count == 0) first_pos = pos;
        pattern = (pattern << 1) | ((c == cells - 1) ? 1 : 0);
        count++;
      end
    end
    trk_pos = pos[19:0];
    res.pattern = 24'(pattern << (24 - count));
    res.count = 5'(count);
    res.first_pos = first_pos[19:0];
    res.wrapped = wrap;
    res.cksum_err = err;
    expected_cells.push_back(res);
  endfunction

  always @(posedge clk_i) begin : check_results
    cell_result_t exp_c, got_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_c = m_axis_tdata[50:0];
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected transaction", 0, m_axis_tdata);
      end else begin
        exp_c = expected_cells.pop_front();
        if (got_c.pattern !== exp_c.pattern)
          report_mismatch("cell_pattern", exp_c.pattern, got_c.pattern);
        if (got_c.count !== exp_c.count)
          report_mismatch("cell_count", exp_c.count, got_c.count);
        if (got_c.first_pos !== exp_c.first_pos)
          report_mismatch("first_cell_position", exp_c.first_pos, got_c.first_pos);
        if (got_c.wrapped !== exp_c.wrapped)
          report_mismatch("wrapped", exp_c.wrapped, got_c.wrapped);
        if (got_c.cksum_err !== exp_c.cksum_err)
          report_mismatch("checksum_error", exp_c.cksum_err, got_c.cksum_err);
        if (m_axis_tdata[55:51] !== 5'd0)
          report_mismatch("tdata pad", 0, m_axis_tdata[55:51]);
      end
    end
  end

  // entered and left at a falling edge; tvalid stays high for back-to-back items
  task automatic send_item(logic [2:0] op, logic [7:0] din);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= din;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_byte(op, din);
    if (op >= OP_GAP && op <= OP_FILL) cells_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained(int extra);
    while (expected_cells.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TRACK_CELLS: cfg_track_cells = val;
      REG_CKSUM_REGEN: cfg_regen = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(logic [CFG_W-1:0] len, logic regen);
    hold_input();
    wait_drained(LAT_SLACK);
    write_reg(REG_TRACK_CELLS, len);
    write_reg(REG_CKSUM_REGEN, {{(CFG_W-1){1'b0}}, regen});
  endtask

  function automatic logic [CFG_W-1:0] pick_track_len();
    case ($urandom_range(0, 9))
      0: return LEN_MIN;
      1: return CFG_W'($urandom_range(0, 63));
      2: return CFG_W'($urandom);
      3: return CFG_W'(TRACK_MAX);
      default: return CFG_W'($urandom_range(64, 2000));
    endcase
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_item(OP_GAP, 8'hA5);
    send_item(OP_SYNC, 8'h00);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'h80);
    send_item(OP_CKLOW, trk_sum[7:0]);
    send_item(OP_CKHIGH, trk_sum[15:8]);
    send_item(OP_FILL, 8'h3C);
    // low byte wrong, high byte right
    send_item(OP_BEGIN, 8'hFF);
    send_item(OP_DATA, 8'($urandom));
    send_item(OP_CKLOW, trk_sum[7:0] ^ 8'h01);
    send_item(OP_CKHIGH, trk_sum[15:8]);
    // low byte right, high byte wrong
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_DATA, 8'($urandom));
    send_item(OP_CKLOW, trk_sum[7:0]);
    send_item(OP_CKHIGH, trk_sum[15:8] ^ 8'h80);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_GAP, 8'hFF);
    configure(21'd200000, 1'b1);
    send_item(OP_DATA, 8'($urandom));
    send_item(OP_CKLOW, 8'($urandom));
    send_item(OP_CKHIGH, 8'($urandom));
    send_item(OP_FILL, 8'($urandom));
  endtask

  task automatic test_track_wrap();
    configure(LEN_MIN, 1'b0);
    send_item(OP_BEGIN, 8'h00);
    repeat (10) send_item(OP_SYNC, 8'h00);
    repeat (5) send_item(OP_GAP, 8'h00);
    // below the minimum length clamps to it
    configure(21'd0, 1'b0);
    send_item(OP_BEGIN, 8'h00);
    repeat (6) send_item(OP_SYNC, 8'h00);
    configure(21'd63, 1'b1);
    repeat (6) send_item(OP_DATA, 8'($urandom));
    // length shrinks under the current position
    configure(21'd1000, 1'b0);
    send_item(OP_BEGIN, 8'h00);
    repeat (20) send_item(OP_SYNC, 8'h00);
    configure(LEN_MIN, 1'b0);
    repeat (3) send_item(OP_SYNC, 8'h00);
    configure(21'h1FFFFF, 1'b0);
    send_item(OP_BEGIN, 8'h00);
    repeat (4) send_item(OP_SYNC, 8'h00);
  endtask

  task automatic test_longest_track();
    configure(CFG_W'(TRACK_MAX), 1'b0);
    send_item(OP_BEGIN, 8'h00);
    // position runs on without a wrap on the longest track
    repeat (12) send_item(OP_SYNC, 8'h00);
  endtask

  task automatic send_frame();
    int n;
    send_item(OP_BEGIN, 8'($urandom));
    n = $urandom_range(0, 3);
    repeat (n) send_item(OP_GAP, 8'($urandom));
    n = $urandom_range(0, 2);
    repeat (n) send_item(OP_SYNC, 8'($urandom));
    n = $urandom_range(1, 6);
    repeat (n) send_item(OP_DATA, pick_data());
    send_item(OP_CKLOW, ($urandom_range(0, 9) < 7) ? trk_sum[7:0] : 8'($urandom));
    send_item(OP_CKHIGH, ($urandom_range(0, 9) < 7) ? trk_sum[15:8] : 8'($urandom));
    n = $urandom_range(0, 4);
    repeat (n) send_item(OP_FILL, 8'($urandom));
  endtask

  task automatic test_random_traffic(int src_pct, int snk_pct, int n_cells);
    int goal;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    configure(pick_track_len(), 1'($urandom));
    goal = cells_sent + n_cells;
    while (cells_sent < goal) begin
      if ($urandom_range(0, 39) == 0) begin
        hold_input();
        wait_drained(0);
      end
      if ($urandom_range(0, 7) == 0) begin
        // mid-track change, position is kept
        if ($urandom_range(0, 1)) configure(pick_track_len(), cfg_regen);
        else configure(cfg_track_cells, ~cfg_regen);
      end
      if ($urandom_range(0, 99) < 85) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 4)) send_item(3'($urandom_range(0, 7)), 8'($urandom));
      end
    end
  endtask

  initial begin
    reset_image();
    src_idle_pct = 23;
    snk_idle_pct = 74;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_track_wrap();
    test_longest_track();
    test_random_traffic(23, 74, 250);
    test_random_traffic(74, 23, 250);
    test_random_traffic(0, 0, 250);
    hold_input();
    wait_drained(10);
    if (expected_cells.size() != 0)
      report_mismatch("results missing", expected_cells.size(), 0);
    if (mismatches == 0) begin
      $display("[system_track_cell_encoder] OK");
    end else begin
      $display("[system_track_cell_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("[system_track_cell_encoder] ERROR");
    $finish;
  end

endmodule
